// ===== design/btcks_pkg.sv =====
// Package for the binary trie closest-key search block.
// Holds the sizing constants, operation codes and request/response structs.
// No dependencies.
package btcks_pkg;

    localparam int KEY_BITS   = 32;
    localparam int NODE_COUNT = 4096;
    localparam int DATA_BITS  = 32;

    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int FREE_W = $clog2(NODE_COUNT + 1);
    localparam int LVL_W  = $clog2(KEY_BITS + 1);
    localparam int CAP_W  = $clog2(NODE_COUNT + KEY_BITS + 1) + 1;

    localparam logic [1:0] OP_INSERT  = 2'd0;
    localparam logic [1:0] OP_EXACT   = 2'd1;
    localparam logic [1:0] OP_CLOSEST = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] value;
    } in_req_t;

    typedef struct packed {
        logic        found;
        logic [31:0] leaf_value;
        logic        pool_full;
    } out_rsp_t;

    // One trie node: the links for a zero bit and a one bit. Zero means no child.
    typedef struct packed {
        logic [NODE_W-1:0] one;
        logic [NODE_W-1:0] zero;
    } link_entry_t;

endpackage

// ===== design/binary_trie_closest_key_search.sv =====
// Top level of the binary trie closest-key search block.
// Uses btcks_pkg for constants and the request/response structs.
// Holds the node link memory, the leaf data memory and the walk sequencer.

// The block keeps a binary trie of KEY_BITS-bit keys in a pool of NODE_COUNT
// nodes and serves one request at a time: insert, exact search or closest
// search, each answered by exactly one response; an unused operation code
// gets an empty response. A search does one link-memory read per trie level,
// then collects the leaf-memory read and loads the output register. An
// insert of an existing key writes its leaf in place of the leaf read. An
// insert that allocates nodes walks the levels up to the first missing link,
// writes each further fresh node in turn, then the leaf, and then loads the
// output register. A rejected insert or a missed search ends early at the
// level where the path stops.
// The walk is paced by the link memory: each level needs the previous
// level's read data to form the next address. The next request is accepted
// from the cycle after the previous response is loaded, even while that
// response still waits for m_ready. After reset the block is ready at once:
// only the root node has a reset value, and it is covered by a single valid
// flag, so there is no clearing pass. A closest search on the bitwise
// complement of a key returns the data of a stored key that gives the
// maximum XOR with it.
module binary_trie_closest_key_search (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  btcks_pkg::in_req_t s_req,
    output logic               m_valid,
    input  logic               m_ready,
    output btcks_pkg::out_rsp_t m_rsp
);
    import btcks_pkg::*;

    // The sequencer walks one trie level per cycle in S_WALK. S_ALLOC writes
    // one freshly allocated node per cycle. S_LEAF collects the leaf read and
    // S_RESP hands the finished response to the output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_ALLOC,
        S_LEAF,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [1:0]          op_reg, op_next;
    logic [KEY_BITS-1:0] key_sh_reg, key_sh_next;
    logic [DATA_BITS-1:0] value_reg, value_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [LVL_W-1:0]    level_reg, level_next;
    logic [FREE_W-1:0]   next_free_reg, next_free_next;
    logic                root_valid_reg, root_valid_next;
    out_rsp_t            res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_rsp_t            m_rsp_reg, m_rsp_next;

    // Node link memory and leaf data memory, both with registered read data.
    link_entry_t          link_mem [NODE_COUNT];
    logic [DATA_BITS-1:0] leaf_mem [NODE_COUNT];
    link_entry_t          link_rdata_reg;
    logic [DATA_BITS-1:0] leaf_rdata_reg;

    logic [NODE_W-1:0]    link_raddr;
    logic                 link_we;
    logic [NODE_W-1:0]    link_waddr;
    link_entry_t          link_wdata;
    logic                 leaf_we;
    logic [NODE_W-1:0]    leaf_waddr;

    // Walk decode for the node whose links are in link_rdata_reg.
    link_entry_t          cur_links;
    logic                 cur_bit;
    logic [NODE_W-1:0]    direct_link;
    logic [NODE_W-1:0]    other_link;
    logic [NODE_W-1:0]    nxt;
    logic                 missing;
    logic                 last_level;
    logic [CAP_W-1:0]     cap_sum;
    logic                 pool_short;
    logic [NODE_W-1:0]    fresh_idx;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    always_comb begin
        // The root's links read as null until the root is first written.
        cur_links   = (node_reg == '0 && !root_valid_reg) ? '0 : link_rdata_reg;
        cur_bit     = key_sh_reg[KEY_BITS-1];
        direct_link = cur_bit ? cur_links.one : cur_links.zero;
        other_link  = cur_bit ? cur_links.zero : cur_links.one;
        if (op_reg == OP_CLOSEST && direct_link == '0) begin
            nxt = other_link;
        end else begin
            nxt = direct_link;
        end
        missing    = (nxt == '0);
        last_level = (level_reg == LVL_W'(KEY_BITS - 1));
        // Every level from the first missing link down needs one new node.
        cap_sum    = CAP_W'(next_free_reg) + CAP_W'(KEY_BITS) - CAP_W'(level_reg);
        pool_short = (cap_sum > CAP_W'(NODE_COUNT));
        fresh_idx  = next_free_reg[NODE_W-1:0];
    end

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_sh_next     = key_sh_reg;
        value_next      = value_reg;
        node_next       = node_reg;
        level_next      = level_reg;
        next_free_next  = next_free_reg;
        root_valid_next = root_valid_reg;
        res_next        = res_reg;
        m_rsp_next      = m_rsp_reg;
        m_valid_next    = m_valid_reg;
        link_raddr      = nxt;
        link_we         = 1'b0;
        link_waddr      = node_reg;
        link_wdata      = '0;
        leaf_we         = 1'b0;
        leaf_waddr      = node_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                link_raddr = '0;
                if (s_valid) begin
                    op_next     = s_req.operation;
                    key_sh_next = KEY_BITS'(s_req.key);
                    value_next  = DATA_BITS'(s_req.value);
                    node_next   = '0;
                    level_next  = '0;
                    if (s_req.operation == OP_INSERT || s_req.operation == OP_EXACT
                        || s_req.operation == OP_CLOSEST) begin
                        state_next = S_WALK;
                    end else begin
                        res_next   = '0;
                        state_next = S_RESP;
                    end
                end
            end

            S_WALK: begin
                if (missing) begin
                    if (op_reg != OP_INSERT) begin
                        res_next   = '0;
                        state_next = S_RESP;
                    end else if (pool_short) begin
                        res_next           = '0;
                        res_next.pool_full = 1'b1;
                        state_next         = S_RESP;
                    end else begin
                        // Hook the first fresh node into the existing parent.
                        link_we    = 1'b1;
                        link_waddr = node_reg;
                        link_wdata = cur_links;
                        if (cur_bit) begin
                            link_wdata.one = fresh_idx;
                        end else begin
                            link_wdata.zero = fresh_idx;
                        end
                        node_next      = fresh_idx;
                        next_free_next = next_free_reg + FREE_W'(1);
                        level_next     = level_reg + LVL_W'(1);
                        key_sh_next    = key_sh_reg << 1;
                        state_next     = S_ALLOC;
                    end
                end else if (last_level) begin
                    if (op_reg == OP_INSERT) begin
                        // Existing key: overwrite its data, no allocation.
                        leaf_we             = 1'b1;
                        leaf_waddr          = nxt;
                        res_next.found      = 1'b1;
                        res_next.leaf_value = 32'(value_reg);
                        res_next.pool_full  = 1'b0;
                        state_next          = S_RESP;
                    end else begin
                        state_next = S_LEAF;
                    end
                end else begin
                    node_next   = nxt;
                    level_next  = level_reg + LVL_W'(1);
                    key_sh_next = key_sh_reg << 1;
                end
            end

            S_ALLOC: begin
                if (level_reg == LVL_W'(KEY_BITS)) begin
                    leaf_we             = 1'b1;
                    leaf_waddr          = node_reg;
                    res_next.found      = 1'b1;
                    res_next.leaf_value = 32'(value_reg);
                    res_next.pool_full  = 1'b0;
                    state_next          = S_RESP;
                end else begin
                    // A fresh node has only the one link to the next fresh node.
                    link_we    = 1'b1;
                    link_waddr = node_reg;
                    link_wdata = '0;
                    if (cur_bit) begin
                        link_wdata.one = fresh_idx;
                    end else begin
                        link_wdata.zero = fresh_idx;
                    end
                    node_next      = fresh_idx;
                    next_free_next = next_free_reg + FREE_W'(1);
                    level_next     = level_reg + LVL_W'(1);
                    key_sh_next    = key_sh_reg << 1;
                end
            end

            S_LEAF: begin
                res_next.found      = 1'b1;
                res_next.leaf_value = 32'(leaf_rdata_reg);
                res_next.pool_full  = 1'b0;
                state_next          = S_RESP;
            end

            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_rsp_next   = res_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (link_we && link_waddr == '0) begin
            root_valid_next = 1'b1;
        end
    end

    // A read that lands on the entry being written in the same cycle returns
    // the old contents, but that data is never used: after a write the walk
    // only allocates, and the next request starts its root read only after the
    // leaf write and the output load that close the insert.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rdata_reg <= link_mem[link_raddr];
    end

    always_ff @(posedge aclk) begin
        if (leaf_we) begin
            leaf_mem[leaf_waddr] <= value_reg;
        end
        leaf_rdata_reg <= leaf_mem[nxt];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            next_free_reg  <= FREE_W'(1);
            root_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_free_reg  <= next_free_next;
            root_valid_reg <= root_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        op_reg     <= op_next;
        key_sh_reg <= key_sh_next;
        value_reg  <= value_next;
        node_reg   <= node_next;
        level_reg  <= level_next;
        res_reg    <= res_next;
        m_rsp_reg  <= m_rsp_next;
    end

endmodule

// ===== design/btcks_checker.sv =====
// Port-level checker for the binary trie closest-key search block.
// Uses btcks_pkg for the response struct; bound to the top level below.
module btcks_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input btcks_pkg::in_req_t  s_req,
    input logic                m_valid,
    input logic                m_ready,
    input btcks_pkg::out_rsp_t m_rsp
);
    import btcks_pkg::*;

    // A pending response holds still until it is taken.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("response changed while stalled");

    // A rejected insert never reports a leaf.
    a_full_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rsp.pool_full |-> !m_rsp.found && m_rsp.leaf_value == '0)
        else $error("pool_full response carries a leaf");

    // Without a leaf the data reads as zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rsp.found |-> m_rsp.leaf_value == '0)
        else $error("miss response has nonzero data");

    // Requests are served one at a time.
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in progress");

    // Reset leaves no response pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid right after reset");

endmodule

bind binary_trie_closest_key_search btcks_checker u_btcks_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for binary_trie_closest_key_search.
// Depends on btcks_pkg and the block's top level only; it predicts every response
// with its own software trie and compares each one as it is accepted.
`timescale 1ns / 100ps

module testbench;

    import btcks_pkg::*;

    // Operation code that the block must answer with an empty response.
    localparam logic [1:0]  OP_UNUSED      = 2'd3;
    localparam logic [31:0] LEAF_MASK      = 32'((64'd1 << DATA_BITS) - 64'd1);
    localparam int          RSP_HOLD_CYCLES = 300;
    localparam int          DRAIN_CYCLES    = KEY_BITS + 8;
    // The limit leaves a wide margin over the slowest correct run.
    localparam int          CYCLE_LIMIT     = 1000000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_req = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_rsp_t m_rsp;

    binary_trie_closest_key_search u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_rsp   (m_rsp)
    );

    // The clock runs with a 4 ns period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Software copy of the trie. Node 0 is the root, and a link of zero
    // means the branch is empty because the root is never a child.
    // ------------------------------------------------------------------
    int          trie_link [NODE_COUNT][2];
    logic [31:0] trie_leaf [NODE_COUNT];
    int          trie_next_free;
    logic [31:0] stored_keys[$];   // Every key that has a leaf, for reuse as stimulus.
    out_rsp_t    pending_rsp_q[$]; // Predicted responses, oldest first.

    int mismatch_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    logic        rsp_hold = 1'b0;
    logic [23:0] key_prefix[4];
    event        hold_rsp_ev;

    // Follows the stored path of a key from the root and returns how many
    // levels exist; node ends on the last node reached.
    function automatic int trie_depth(input logic [31:0] key, output int node);
        int depth;
        node = 0;
        depth = 0;
        while (depth < KEY_BITS && trie_link[node][key[KEY_BITS-1-depth]] != 0) begin
            node = trie_link[node][key[KEY_BITS-1-depth]];
            depth++;
        end
        return depth;
    endfunction

    // Applies one accepted request to the software trie and returns the
    // response the block has to produce for it.
    function automatic out_rsp_t trie_predict(input in_req_t req);
        out_rsp_t rsp;
        int       node;
        int       depth;
        int       lvl;
        int       nxt;
        logic     b;
        rsp = '0;
        case (req.operation)
            OP_INSERT: begin
                depth = trie_depth(req.key, node);
                // An insert must fit entirely, or the trie stays untouched.
                if (trie_next_free + (KEY_BITS - depth) > NODE_COUNT) begin
                    rsp.pool_full = 1'b1;
                end else begin
                    for (lvl = depth; lvl < KEY_BITS; lvl++) begin
                        b = req.key[KEY_BITS-1-lvl];
                        trie_link[trie_next_free][0] = 0;
                        trie_link[trie_next_free][1] = 0;
                        trie_link[node][b] = trie_next_free;
                        node = trie_next_free;
                        trie_next_free++;
                    end
                    if (depth < KEY_BITS) begin
                        stored_keys.push_back(req.key);
                    end
                    trie_leaf[node] = req.value & LEAF_MASK;
                    rsp.found = 1'b1;
                    rsp.leaf_value = trie_leaf[node];
                end
            end
            OP_EXACT, OP_CLOSEST: begin
                node = 0;
                rsp.found = 1'b1;
                for (lvl = 0; lvl < KEY_BITS && rsp.found; lvl++) begin
                    b = req.key[KEY_BITS-1-lvl];
                    nxt = trie_link[node][b];
                    // Closest search falls back to the other branch.
                    if (req.operation == OP_CLOSEST && nxt == 0) begin
                        nxt = trie_link[node][!b];
                    end
                    if (nxt == 0) begin
                        rsp.found = 1'b0;
                    end
                    node = nxt;
                end
                if (rsp.found) begin
                    rsp.leaf_value = trie_leaf[node];
                end
            end
            default: begin
                rsp = '0;
            end
        endcase
        return rsp;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: response field %s mismatch: expected 0x%08h, actual 0x%08h",
                     $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Response checking and request prediction share one process, so the
    // queue is updated in a fixed order at each edge. Both channels are
    // sampled right after the edge, before any register in the block moves.
    always @(posedge aclk) begin : check_rsp
        out_rsp_t exp_rsp;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_rsp_q.size() == 0) begin
                    $display("%0t: unexpected response: expected none, actual %p",
                             $time, m_rsp);
                    mismatch_count++;
                end else begin
                    exp_rsp = pending_rsp_q.pop_front();
                    compare_field("found", 32'(exp_rsp.found), 32'(m_rsp.found));
                    compare_field("leaf_value", exp_rsp.leaf_value, m_rsp.leaf_value);
                    compare_field("pool_full", 32'(exp_rsp.pool_full), 32'(m_rsp.pool_full));
                end
            end
            if (s_valid && s_ready) begin
                pending_rsp_q.push_back(trie_predict(s_req));
            end
        end
    end

    // The receiver stalls at random, except during a long hold-off, when it
    // refuses every response.
    always @(posedge aclk) begin
        if (rsp_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always begin
        @(hold_rsp_ev);
        rsp_hold <= 1'b1;
        repeat (RSP_HOLD_CYCLES) @(posedge aclk);
        rsp_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[binary_trie_closest_key_search] ERROR");
            $finish;
        end
    end

    // Offers one request and returns at the edge where it is accepted, with
    // valid still high so that a following request can go out back to back.
    task automatic send_request(input logic [1:0] op, input logic [31:0] key,
                                input logic [31:0] value);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_req <= '{operation: op, key: key, value: value};
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops offering requests until every predicted response has come back.
    task automatic wait_all_responses();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rsp_q.size() != 0) @(posedge aclk);
    endtask

    // Most keys come from four shared prefixes with random low bytes, so the
    // trie gets dense branching and repeated keys without using up the pool.
    // A few keys are fully random or reuse stored ones or their complements.
    function automatic logic [31:0] random_trie_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 6 || stored_keys.size() == 0) begin
            return $urandom;
        end else if (pick < 22) begin
            return stored_keys[$urandom_range(stored_keys.size() - 1)];
        end else if (pick < 28) begin
            return ~stored_keys[$urandom_range(stored_keys.size() - 1)];
        end
        return {key_prefix[$urandom_range(3)], 8'($urandom)};
    endfunction

    // Extremes, every operation and each corner case, on an empty trie first.
    task automatic test_directed();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        send_request(OP_CLOSEST, 32'h1234_5678, 32'h0);   // Empty trie: nothing to reach.
        send_request(OP_EXACT, 32'h0, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'h0, 32'h0);
        send_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_EXACT, 32'h0, 32'h0);
        send_request(OP_EXACT, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_EXACT, 32'h8000_0000, 32'h0);     // Misses near the root.
        send_request(OP_EXACT, 32'h0000_0001, 32'h0);     // Misses at the last level.
        send_request(OP_INSERT, 32'h0, 32'hDEAD_BEEF);     // Overwrites an existing leaf.
        send_request(OP_EXACT, 32'h0, 32'h0);
        send_request(OP_CLOSEST, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 32'hA5A5_5A5A, 32'h1234_5678);
        send_request(OP_INSERT, 32'hA5A5_5A5B, 32'h8765_4321);
        send_request(OP_CLOSEST, ~32'hA5A5_5A5A, 32'h0);  // Maximum-XOR partner.
        send_request(OP_CLOSEST, 32'hA5A5_5A59, 32'h0);
        send_request(OP_UNUSED, 32'h0, 32'h0);
        send_request(OP_CLOSEST, 32'h0000_0001, 32'h0);
        wait_all_responses();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int stall_pct);
        int          n;
        int          pick;
        logic [1:0]  op;
        logic [31:0] value;
        send_idle_pct = send_pct;
        rsp_stall_pct = stall_pct;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                op = OP_INSERT;
            end else if (pick < 68) begin
                op = OP_EXACT;
            end else if (pick < 97) begin
                op = OP_CLOSEST;
            end else begin
                op = OP_UNUSED;
            end
            pick = $urandom_range(9);
            value = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
            send_request(op, random_trie_key(), value);
        end
        wait_all_responses();
    endtask

    // The receiver holds off while requests keep coming, so the block parks a
    // response, takes one more request and then stops taking requests until the hold ends.
    task automatic test_backpressure();
        int n;
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        -> hold_rsp_ev;
        for (n = 0; n < 10; n++) begin
            send_request((n % 2 == 0) ? OP_INSERT : OP_CLOSEST, random_trie_key(), $urandom);
        end
        wait_all_responses();
    endtask

    // Fills the node pool to the last node. Each insert branches off a stored
    // key at a chosen bit, so it never needs more nodes than remain, except
    // for the deliberate attempts that come up one node short.
    task automatic test_pool_exhaustion();
        logic [31:0] base;
        logic [31:0] key;
        logic [31:0] low_mask;
        int          room;
        int          p;
        int          tries;
        send_idle_pct = 7;
        rsp_stall_pct = 7;
        tries = 0;
        while (trie_next_free < NODE_COUNT && tries < 1500) begin
            room = NODE_COUNT - trie_next_free;
            base = stored_keys[$urandom_range(stored_keys.size() - 1)];
            if (room < KEY_BITS && $urandom_range(3) == 0) begin
                p = room;
            end else begin
                p = $urandom_range(((room > KEY_BITS) ? KEY_BITS : room) - 1);
            end
            low_mask = (32'd1 << p) - 32'd1;
            key = ((base ^ (32'd1 << p)) & ~low_mask) | (32'($urandom) & low_mask);
            send_request(OP_INSERT, key, $urandom);
            wait_all_responses();
            tries++;
        end
        // With the pool used up, new keys are refused but known keys update.
        send_request(OP_INSERT, ~stored_keys[0] ^ 32'h0000_0001, $urandom);
        send_request(OP_INSERT, 32'($urandom), $urandom);
        send_request(OP_INSERT, stored_keys[0], 32'hFFFF_FFFF);
        send_request(OP_EXACT, stored_keys[0], 32'h0);
        send_request(OP_INSERT, stored_keys[stored_keys.size() - 1], 32'h0);
        send_request(OP_EXACT, stored_keys[stored_keys.size() - 1], 32'h0);
        send_request(OP_CLOSEST, 32'($urandom), 32'h0);
        send_request(OP_CLOSEST, ~stored_keys[0], 32'h0);
        send_request(OP_UNUSED, 32'($urandom), 32'($urandom));
        wait_all_responses();
    endtask

    initial begin
        int k;
        for (k = 0; k < NODE_COUNT; k++) begin
            trie_link[k][0] = 0;
            trie_link[k][1] = 0;
            trie_leaf[k] = '0;
        end
        trie_next_free = 1;
        for (k = 0; k < 4; k++) begin
            key_prefix[k] = 24'($urandom);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_traffic(300, 0, 0);
        test_backpressure();
        test_random_traffic(300, 83, 0);
        test_random_traffic(300, 0, 83);
        test_random_traffic(300, 7, 7);
        test_pool_exhaustion();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
            $display("[binary_trie_closest_key_search] OK");
        end else begin
            $display("[binary_trie_closest_key_search] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/btcks_pkg.sv
design/binary_trie_closest_key_search.sv
design/btcks_checker.sv
tb/testbench.sv
